>>> hw/rtl/ist_pkg.sv
// ----------------------------------------------------------------------------
// ist_pkg: shared types and constants of the integer set table
// Operation codes, result status codes and the request/result structs passed
// between the table front end and its scan engine.
// ----------------------------------------------------------------------------
package ist_pkg;

  // default number of slots in the set
  localparam int CAPACITY_DEF = 16;

  localparam int OP_W    = 2;
  localparam int DATA_W  = 32;
  localparam int COUNT_W = 5;

  // operation codes; any other code behaves as a query
  localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_NOCHANGE = 2'd1,
    ST_FULL     = 2'd2
  } status_t;

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic               found;
    logic [COUNT_W-1:0] count;
    status_t            status;
  } res_t;

endpackage

>>> hw/rtl/integer_set_table.sv
// ----------------------------------------------------------------------------
// integer_set_table: set of distinct signed 32-bit values
// Add, remove or query one value per request; each request returns whether
// the value was present, the element count afterwards and a status.
// ----------------------------------------------------------------------------
// flow: a request scans the stored entries up to a hit or the last one, with
//   no scan on an empty set; a hit remove below the tail then compacts
// throughput: the engine takes one request at a time and accepts the next
//   once its result has moved into the output register; the single comparator
//   reads one stored entry per cycle
// reset: synchronous active-low rst_n empties the set and clears both sides
module integer_set_table #(
  parameter int CAPACITY = ist_pkg::CAPACITY_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // request channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [ist_pkg::OP_W-1:0]          in_opcode,
  input  logic signed [ist_pkg::DATA_W-1:0] in_value,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_found,
  output logic [ist_pkg::COUNT_W-1:0]       out_count,
  output logic [1:0]                        out_status
);

  ist_pkg::req_t req;
  ist_pkg::res_t res;
  logic          req_ready;
  logic          res_valid;
  logic          res_take;

  logic                        out_valid_r;
  logic                        out_found_r;
  logic [ist_pkg::COUNT_W-1:0] out_count_r;
  logic [1:0]                  out_status_r;

  // raw bit pattern goes to the engine, only equality matters
  assign req.opcode = in_opcode;
  assign req.value  = in_value;

  // a request is taken only while the engine sits idle
  assign in_stall = !req_ready;

  ist_engine #(
    .CAPACITY (CAPACITY)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_valid),
    .req       (req),
    .req_ready (req_ready),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take)
  );

  // output register: engine result moves in when the slot is empty or
  // the downstream side takes the current one this cycle
  assign res_take = res_valid && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (res_take) begin
      out_found_r  <= res.found;
      out_count_r  <= res.count;
      out_status_r <= res.status;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_found  = out_found_r;
  assign out_count  = out_count_r;
  assign out_status = out_status_r;

endmodule

>>> hw/rtl/ist_engine.sv
// ----------------------------------------------------------------------------
// ist_engine: scan and update sequencer of the integer set table
// Holds the entry memory and the element count; one comparator walks the
// stored entries, remove compacts the tail one entry per cycle.
// ----------------------------------------------------------------------------
module ist_engine #(
  parameter int CAPACITY = ist_pkg::CAPACITY_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          req_valid,
  input  ist_pkg::req_t req,
  output logic          req_ready,
  output logic          res_valid,
  output ist_pkg::res_t res,
  input  logic          res_take
);

  localparam int IW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW       = $clog2(CAPACITY + 1);
  localparam int DW       = ist_pkg::DATA_W;
  localparam int CntOutW  = ist_pkg::COUNT_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_SHIFT,
    S_RESP
  } state_t;

  state_t                     state_r, state_nxt;
  logic [ist_pkg::OP_W-1:0]   op_r, op_nxt;
  logic [DW-1:0]              val_r, val_nxt;
  logic [CW-1:0]              cnt_r, cnt_nxt;
  logic [CW-1:0]              rd_idx_r, rd_idx_nxt;
  logic [CW-1:0]              cmp_idx_r, cmp_idx_nxt;
  logic                       cmp_vld_r, cmp_vld_nxt;
  logic                       hit_r, hit_nxt;
  logic [CW-1:0]              slot_r, slot_nxt;
  ist_pkg::status_t           status_r, status_nxt;

  logic [DW-1:0]              mem [CAPACITY];
  logic [DW-1:0]              rd_data_r;
  logic                       mem_we;
  logic [IW-1:0]              wr_addr;
  logic [DW-1:0]              wr_data;
  logic [IW-1:0]              rd_addr;

  logic                       hit_now;
  logic                       last_cmp;
  logic                       more_to_read;
  logic [CW-1:0]              sh_dst;
  logic [CW-1:0]              slot_next;

  // entry memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_addr      = rd_idx_r[IW-1:0];
  assign hit_now      = cmp_vld_r && (rd_data_r == val_r);
  assign last_cmp     = cmp_vld_r && ((cmp_idx_r + CW'(1)) == cnt_r);
  assign more_to_read = rd_idx_r < cnt_r;
  assign sh_dst       = cmp_idx_r - CW'(1);
  assign slot_next    = slot_r + CW'(1);

  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    val_nxt     = val_r;
    cnt_nxt     = cnt_r;
    rd_idx_nxt  = rd_idx_r;
    cmp_idx_nxt = cmp_idx_r;
    cmp_vld_nxt = cmp_vld_r;
    hit_nxt     = hit_r;
    slot_nxt    = slot_r;
    status_nxt  = status_r;
    mem_we      = 1'b0;
    wr_addr     = cnt_r[IW-1:0];
    wr_data     = val_r;

    unique case (state_r)
      S_IDLE: begin
        if (req_valid) begin
          op_nxt      = req.opcode;
          val_nxt     = req.value;
          rd_idx_nxt  = '0;
          cmp_vld_nxt = 1'b0;
          hit_nxt     = 1'b0;
          state_nxt   = (cnt_r == '0) ? S_DECIDE : S_SCAN;
        end
      end

      S_SCAN: begin
        if (hit_now) begin
          hit_nxt     = 1'b1;
          slot_nxt    = cmp_idx_r;
          cmp_vld_nxt = 1'b0;
          state_nxt   = S_DECIDE;
        end else if (last_cmp) begin
          hit_nxt     = 1'b0;
          cmp_vld_nxt = 1'b0;
          state_nxt   = S_DECIDE;
        end else if (more_to_read) begin
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = rd_idx_r;
          rd_idx_nxt  = rd_idx_r + CW'(1);
        end else begin
          cmp_vld_nxt = 1'b0;
        end
      end

      S_DECIDE: begin
        state_nxt = S_RESP;
        unique case (op_r)
          ist_pkg::OP_ADD: begin
            if (hit_r) begin
              status_nxt = ist_pkg::ST_NOCHANGE;
            end else if (cnt_r >= CW'(CAPACITY)) begin
              status_nxt = ist_pkg::ST_FULL;
            end else begin
              mem_we     = 1'b1;
              cnt_nxt    = cnt_r + CW'(1);
              status_nxt = ist_pkg::ST_DONE;
            end
          end
          ist_pkg::OP_REMOVE: begin
            if (!hit_r) begin
              status_nxt = ist_pkg::ST_NOCHANGE;
            end else if (slot_next < cnt_r) begin
              // later entries move down one slot
              rd_idx_nxt  = slot_next;
              cmp_vld_nxt = 1'b0;
              state_nxt   = S_SHIFT;
            end else begin
              cnt_nxt    = cnt_r - CW'(1);
              status_nxt = ist_pkg::ST_DONE;
            end
          end
          default: begin
            status_nxt = hit_r ? ist_pkg::ST_DONE : ist_pkg::ST_NOCHANGE;
          end
        endcase
      end

      S_SHIFT: begin
        if (cmp_vld_r) begin
          mem_we  = 1'b1;
          wr_addr = sh_dst[IW-1:0];
          wr_data = rd_data_r;
        end
        if (last_cmp) begin
          cnt_nxt     = cnt_r - CW'(1);
          status_nxt  = ist_pkg::ST_DONE;
          cmp_vld_nxt = 1'b0;
          state_nxt   = S_RESP;
        end else if (more_to_read) begin
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = rd_idx_r;
          rd_idx_nxt  = rd_idx_r + CW'(1);
        end else begin
          cmp_vld_nxt = 1'b0;
        end
      end

      S_RESP: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_r     <= '0;
      cmp_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      cmp_vld_r <= cmp_vld_nxt;
    end
    op_r      <= op_nxt;
    val_r     <= val_nxt;
    rd_idx_r  <= rd_idx_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    hit_r     <= hit_nxt;
    slot_r    <= slot_nxt;
    status_r  <= status_nxt;
  end

  assign req_ready  = (state_r == S_IDLE);
  assign res_valid  = (state_r == S_RESP);
  assign res.found  = hit_r;
  assign res.count  = CntOutW'(cnt_r);
  assign res.status = status_r;

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(CAPACITY))
    else $error("element count above capacity");

  a_write_place: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_DECIDE || state_r == S_SHIFT))
    else $error("entry write outside update phase");

  a_full_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && status_r == ist_pkg::ST_FULL) |-> (!hit_r && cnt_r == CW'(CAPACITY)))
    else $error("full status with hit or room left");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (req_valid && req_ready) |=> !req_ready)
    else $error("engine idle right after a request");
`endif

endmodule

>>> tb/sv/integer_set_table_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// integer_set_table_test: self-checking bench for the integer set table
// Drives add, remove, query and unused-opcode requests through the
// valid/stall request channel and predicts every result from a local copy
// of the set. Each accepted result is compared field by field with the
// oldest pending prediction. The sender works in bursts with random gaps
// and the receiver stalls on its own pattern, with one long hold-off.
// ----------------------------------------------------------------------------
module integer_set_table_test;

  localparam int SET_CAPACITY = ist_pkg::CAPACITY_DEF;
  // code with no operation of its own, behaves as a query
  localparam logic [ist_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
  // worst latency is a full scan plus a full compaction, padded
  localparam int DRAIN_CYCLES = 2 * SET_CAPACITY + 20;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam longint RUN_LIMIT_NS = 64'd10_000_000;
  localparam int POOL_SIZE = 24;
  localparam int MAX_REPORTS = 200;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // request channel, all known from time zero
  logic                              in_valid = 1'b0;
  logic                              in_stall;
  logic [ist_pkg::OP_W-1:0]          in_opcode = ist_pkg::OP_QUERY;
  logic signed [ist_pkg::DATA_W-1:0] in_value = '0;

  // result channel
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic                        out_found;
  logic [ist_pkg::COUNT_W-1:0] out_count;
  logic [1:0]                  out_status;

  // local copy of the set, slot order kept as the block keeps it
  logic [ist_pkg::DATA_W-1:0] set_members[$];
  // predicted results in request order
  ist_pkg::res_t expected_results[$];

  // values reused often so adds and removes hit stored members
  logic [ist_pkg::DATA_W-1:0] value_pool[POOL_SIZE];

  int error_count = 0;
  int result_index = 0;
  int burst_left = 0;
  bit hold_off_req = 1'b0;

  integer_set_table #(
    .CAPACITY (SET_CAPACITY)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_opcode  (in_opcode),
    .in_value   (in_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_found  (out_found),
    .out_count  (out_count),
    .out_status (out_status)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // set predictor: applies one request to the local copy, returns the result
  // --------------------------------------------------------------------------
  function automatic ist_pkg::res_t apply_set_op(input logic [ist_pkg::OP_W-1:0] op,
                                                 input logic [ist_pkg::DATA_W-1:0] v);
    ist_pkg::res_t r;
    int slot;
    slot = -1;
    // membership looks at stored members only, equality on the raw bits
    foreach (set_members[i]) begin
      if (slot < 0 && set_members[i] == v) slot = i;
    end
    r.found = (slot >= 0);
    case (op)
      ist_pkg::OP_ADD: begin
        if (slot >= 0) begin
          r.status = ist_pkg::ST_NOCHANGE;
        end else if (set_members.size() >= SET_CAPACITY) begin
          r.status = ist_pkg::ST_FULL;
        end else begin
          set_members.push_back(v);
          r.status = ist_pkg::ST_DONE;
        end
      end
      ist_pkg::OP_REMOVE: begin
        if (slot >= 0) begin
          // later members shift down one slot
          set_members.delete(slot);
          r.status = ist_pkg::ST_DONE;
        end else begin
          r.status = ist_pkg::ST_NOCHANGE;
        end
      end
      default: begin
        // query, and the unused code acting as a query
        r.status = (slot >= 0) ? ist_pkg::ST_DONE : ist_pkg::ST_NOCHANGE;
      end
    endcase
    r.count = ist_pkg::COUNT_W'(set_members.size());
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // one mismatch, one line
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input int got, input int want);
    error_count++;
    if (error_count <= MAX_REPORTS) begin
      $display("mismatch at result %0d: %s got %0d expected %0d",
               result_index, what, got, want);
    end
  endtask

  // --------------------------------------------------------------------------
  // send one request: burst/gap pacing, then hold payload until accepted
  // entered and left in the time step of a rising edge
  // --------------------------------------------------------------------------
  task automatic send_request(input logic [ist_pkg::OP_W-1:0] op,
                              input logic [ist_pkg::DATA_W-1:0] v);
    int idle_cycles;
    if (burst_left == 0) begin
      // mostly short bursts, now and then a long run with no idling
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                              : $urandom_range(1, 8);
      idle_cycles = ($urandom_range(0, 5) == 0) ? $urandom_range(8, 40)
                                               : $urandom_range(0, 3);
      if (idle_cycles > 0) begin
        in_valid <= 1'b0;
        repeat (idle_cycles) @(posedge clk);
      end
    end
    burst_left--;
    in_valid  <= 1'b1;
    in_opcode <= op;
    in_value  <= v;
    // accepted at the first edge with stall low
    do @(posedge clk); while (in_stall);
    expected_results.push_back(apply_set_op(op, v));
  endtask

  // value source: stored members, the shared pool, or any 32-bit pattern
  function automatic logic [ist_pkg::DATA_W-1:0] pick_value();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 4 && set_members.size() != 0)
      return set_members[$urandom_range(0, set_members.size() - 1)];
    if (roll < 8)
      return value_pool[$urandom_range(0, POOL_SIZE - 1)];
    return $urandom;
  endfunction

  // --------------------------------------------------------------------------
  // result checker: every accepted result against the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with no request pending, count", out_count, 0);
      end else begin
        ist_pkg::res_t want;
        want = expected_results.pop_front();
        if (out_found !== want.found)
          report_mismatch("found", out_found, want.found);
        if (out_count !== want.count)
          report_mismatch("count", out_count, want.count);
        if (out_status !== want.status)
          report_mismatch("status", out_status, want.status);
      end
      result_index++;
    end
  end

  // --------------------------------------------------------------------------
  // receiver: stall pattern in phases, plus one long hold-off on request
  // --------------------------------------------------------------------------
  initial begin : receiver
    int hold_left;
    int phase_left;
    int stall_mode;
    hold_left = 0;
    phase_left = 0;
    stall_mode = 0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (phase_left == 0) begin
          stall_mode = $urandom_range(0, 3);
          phase_left = $urandom_range(20, 200);
        end
        phase_left--;
        case (stall_mode)
          0: out_stall <= 1'b0;                         // clean stretch
          1: out_stall <= ($urandom_range(0, 3) == 0);  // light
          2: out_stall <= ($urandom_range(0, 1) != 0);  // half the time
          default: out_stall <= ($urandom_range(0, 3) != 0);  // heavy
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // directed: field extremes and the basic special cases on a small set
  // --------------------------------------------------------------------------
  task automatic test_field_extremes();
    send_request(ist_pkg::OP_QUERY, 32'h0000_0000);    // absent query on empty set
    send_request(ist_pkg::OP_REMOVE, 32'h0000_0000);   // absent remove on empty set
    send_request(ist_pkg::OP_ADD, 32'h8000_0000);      // most negative
    send_request(ist_pkg::OP_ADD, 32'h7FFF_FFFF);      // most positive
    send_request(ist_pkg::OP_ADD, 32'h0000_0000);
    send_request(ist_pkg::OP_ADD, 32'hFFFF_FFFF);      // minus one
    send_request(ist_pkg::OP_ADD, 32'h8000_0000);      // duplicate add
    send_request(OP_UNUSED, 32'hFFFF_FFFF);            // unused code, present value
    send_request(ist_pkg::OP_REMOVE, 32'h7FFF_FFFF);   // middle remove, tail shifts
    send_request(ist_pkg::OP_QUERY, 32'hFFFF_FFFF);    // shifted member still found
  endtask

  // --------------------------------------------------------------------------
  // directed: fill to capacity, then the full-table cases
  // --------------------------------------------------------------------------
  task automatic test_full_table();
    logic [ist_pkg::DATA_W-1:0] fill_value;
    fill_value = 32'h5A5A_0001;
    while (set_members.size() < SET_CAPACITY) begin
      send_request(ist_pkg::OP_ADD, fill_value);
      fill_value = fill_value + 32'h0101_0101;
    end
    send_request(ist_pkg::OP_ADD, 32'h1234_5678);      // dropped, table full
    send_request(ist_pkg::OP_ADD, set_members[5]);     // duplicate while full
    send_request(OP_UNUSED, set_members[SET_CAPACITY - 1]);
    send_request(ist_pkg::OP_QUERY, 32'h1234_5678);    // absent while full
    send_request(ist_pkg::OP_REMOVE, set_members[0]);  // longest compaction
    send_request(ist_pkg::OP_REMOVE, set_members[set_members.size() - 1]);
  endtask

  // --------------------------------------------------------------------------
  // random traffic in phases leaning to fill, drain or mix
  // --------------------------------------------------------------------------
  task automatic test_random_traffic(input int n_requests);
    int add_pct;
    int roll;
    logic [ist_pkg::OP_W-1:0] op;
    add_pct = 50;
    for (int i = 0; i < n_requests; i++) begin
      if (i % 120 == 0) begin
        case ($urandom_range(0, 2))
          0: add_pct = 85;
          1: add_pct = 15;
          default: add_pct = 50;
        endcase
      end
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        op = OP_UNUSED;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < add_pct) op = ist_pkg::OP_ADD;
        else if ($urandom_range(0, 2) != 0) op = ist_pkg::OP_REMOVE;
        else op = ist_pkg::OP_QUERY;
      end
      send_request(op, pick_value());
    end
  endtask

  // --------------------------------------------------------------------------
  // receiver holds off long while requests keep coming, block must back up
  // --------------------------------------------------------------------------
  task automatic test_receiver_hold_off();
    hold_off_req = 1'b1;
    for (int i = 0; i < 12; i++) begin
      send_request((i % 3 == 0) ? ist_pkg::OP_QUERY : ist_pkg::OP_ADD, pick_value());
    end
  endtask

  // --------------------------------------------------------------------------
  // test sequence
  // --------------------------------------------------------------------------
  initial begin : main_sequence
    // pool keeps the extremes plus random patterns, more than the capacity
    value_pool[0] = 32'h8000_0000;
    value_pool[1] = 32'h7FFF_FFFF;
    value_pool[2] = 32'h0000_0000;
    value_pool[3] = 32'hFFFF_FFFF;
    for (int i = 4; i < POOL_SIZE; i++) value_pool[i] = $urandom;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_field_extremes();
    test_full_table();
    test_random_traffic(900);
    test_receiver_hold_off();
    test_random_traffic(950);

    in_valid <= 1'b0;
    // all requests in, wait for every predicted result, then a quiet stretch
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // overall limit, far beyond the slowest correct run
  initial begin : run_limit
    #(RUN_LIMIT_NS);
    $display("Regression FAIL");
    $finish;
  end

endmodule
